// ===== sv/assert_macros.svh =====
// Assertion macros shared by the motion sample smoother RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define MSSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds through reset.
`define MSSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mssc_pkg.sv =====
// Shared widths, reset values, codes and types for the motion sample smoother.
// No dependencies; imported by every module of the block.
package mssc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int EXT_BITS     = 16;
  localparam int GAIN_W       = 16;
  localparam int PERIOD_W     = 16;
  localparam int ACC_DB_W     = 15;
  localparam int VEL_W        = 24;
  localparam int VEL_DB_W     = 23;
  localparam int PRES_TH_W    = 16;
  localparam int VEL_SHIFT    = 8;
  localparam int NUM_AXES     = 3;
  localparam int CFG_DATA_W   = 23;
  localparam int CFG_IDX_W    = 3;

  // Filter state: sample scaled by 2^EXT_BITS, one extra bit for the sign.
  localparam int STATE_W = SAMPLE_WIDTH + EXT_BITS + 1;
  localparam int MAG_W   = SAMPLE_WIDTH + EXT_BITS;
  localparam int PROD_W  = MAG_W + GAIN_W;
  // Rounded state before saturation: holds +2^SAMPLE_WIDTH-1 and negatives.
  localparam int RND_W   = SAMPLE_WIDTH + 2;
  localparam int VPROD_W = SAMPLE_WIDTH + PERIOD_W + 1;
  localparam int VQS_W   = VPROD_W - VEL_SHIFT;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DB      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_DB        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CONTACT   = 3'd5;

  localparam logic [GAIN_W-1:0]    ACCEL_GAIN_RST    = 16'd5958;
  localparam logic [GAIN_W-1:0]    PRESSURE_GAIN_RST = 16'd5958;
  localparam logic [PERIOD_W-1:0]  LOOP_PERIOD_RST   = 16'd655;
  localparam logic [ACC_DB_W-1:0]  ACCEL_DB_RST      = 15'd51;
  localparam logic [VEL_DB_W-1:0]  VEL_DB_RST        = 23'd655;
  localparam logic [PRES_TH_W-1:0] MIN_CONTACT_RST   = 16'd80;

  typedef logic signed [SAMPLE_WIDTH-1:0] acc_t;
  typedef logic signed [VEL_W-1:0]        vel_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_UPD, ST_RND, ST_ACC, ST_VMUL, ST_VRND, ST_MERGE
  } seq_state_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_CONST   = 2'd1,
    MODE_BRAKE   = 2'd2,
    MODE_ACCEL   = 2'd3
  } mode_t;

  // Step strobes from the sequencer to every lane.
  typedef struct packed {
    logic diff_en;
    logic mul_en;
    logic upd_en;
    logic rnd_en;
    logic acc_en;
    logic vmul_en;
    logic vrnd_en;
  } lane_ctrl_t;

endpackage

// ===== sv/mssc_ema_lane.sv =====
// One exponential average lane: difference, gain multiply, state update, round.
// Depends on mssc_pkg.
module mssc_ema_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mssc_pkg::lane_ctrl_t                ctrl,
  input  logic signed [mssc_pkg::SAMPLE_WIDTH:0] sample,
  input  logic [mssc_pkg::GAIN_W-1:0]         gain,
  output logic signed [mssc_pkg::RND_W-1:0]   rnd_val
);
  import mssc_pkg::*;

  logic signed [STATE_W-1:0] state_r, state_nxt;
  logic signed [STATE_W:0]   target, diff, diff_abs;
  logic                      diff_neg_r;
  logic [MAG_W-1:0]          diff_mag_r;
  logic [PROD_W-1:0]         prod_r, prod_rnd;
  logic [MAG_W-1:0]          step;
  logic signed [STATE_W-1:0] state_abs;
  logic [MAG_W-1:0]          state_sum;
  logic [SAMPLE_WIDTH-1:0]   rq;
  logic signed [RND_W-1:0]   rnd_abs, rnd_r;

  always_comb begin
    target   = {sample[SAMPLE_WIDTH], sample, {EXT_BITS{1'b0}}};
    diff     = target - {state_r[STATE_W-1], state_r};
    diff_abs = diff[STATE_W] ? -diff : diff;
    // Round half away from zero on the magnitude.
    prod_rnd = prod_r + PROD_W'(1 << (EXT_BITS - 1));
    step     = prod_rnd[PROD_W-1:EXT_BITS];
    state_nxt = diff_neg_r ? state_r - $signed({1'b0, step})
                           : state_r + $signed({1'b0, step});
    state_abs = state_r[STATE_W-1] ? -state_r : state_r;
    state_sum = state_abs[MAG_W-1:0] + MAG_W'(1 << (EXT_BITS - 1));
    rq        = state_sum[MAG_W-1:EXT_BITS];
    rnd_abs   = $signed({2'b00, rq});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (ctrl.upd_en) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      diff_neg_r <= diff[STATE_W];
      diff_mag_r <= diff_abs[MAG_W-1:0];
    end
    if (ctrl.mul_en) begin
      prod_r <= diff_mag_r * gain;
    end
    if (ctrl.rnd_en) begin
      rnd_r <= state_r[STATE_W-1] ? -rnd_abs : rnd_abs;
    end
  end

  assign rnd_val = rnd_r;

endmodule

// ===== sv/mssc_vel_lane.sv =====
// One axis after filtering: saturate and deadband, period multiply, velocity round.
// Depends on mssc_pkg.
module mssc_vel_lane (
  input  logic                              clk,
  input  mssc_pkg::lane_ctrl_t              ctrl,
  input  logic signed [mssc_pkg::RND_W-1:0] rnd_val,
  input  logic [mssc_pkg::ACC_DB_W-1:0]     acc_db,
  input  logic [mssc_pkg::PERIOD_W-1:0]     period,
  input  logic [mssc_pkg::VEL_DB_W-1:0]     vel_db,
  output mssc_pkg::acc_t                    acc_out,
  output mssc_pkg::vel_t                    vel_out
);
  import mssc_pkg::*;

  localparam logic signed [RND_W-1:0] ACC_MAX =
    {{(RND_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [RND_W-1:0] ACC_MIN =
    {{(RND_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [VQS_W-1:0] VEL_MAX =
    {{(VQS_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
  localparam logic signed [VQS_W-1:0] VEL_MIN =
    {{(VQS_W-VEL_W+1){1'b1}}, {(VEL_W-1){1'b0}}};

  acc_t                           acc_sat, acc_r;
  logic signed [SAMPLE_WIDTH:0]   acc_ext, acc_db_s;
  logic                           acc_in_band;
  logic signed [VPROD_W-1:0]      vprod_r, vprod_abs;
  logic [VPROD_W-2:0]             vsum;
  logic [VQS_W-2:0]               vq;
  logic signed [VQS_W-1:0]        vs;
  vel_t                           vel_sat, vel_r;
  logic signed [VEL_W:0]          vel_ext, vel_db_s;
  logic                           vel_in_band;

  always_comb begin
    if (rnd_val > ACC_MAX) begin
      acc_sat = ACC_MAX[SAMPLE_WIDTH-1:0];
    end else if (rnd_val < ACC_MIN) begin
      acc_sat = ACC_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      acc_sat = rnd_val[SAMPLE_WIDTH-1:0];
    end
    acc_ext     = {acc_sat[SAMPLE_WIDTH-1], acc_sat};
    acc_db_s    = $signed({2'b00, acc_db});
    acc_in_band = (acc_ext < acc_db_s) && (acc_ext > -acc_db_s);

    vprod_abs = vprod_r[VPROD_W-1] ? -vprod_r : vprod_r;
    vsum      = vprod_abs[VPROD_W-2:0] + (VPROD_W-1)'(1 << (VEL_SHIFT - 1));
    vq        = vsum[VPROD_W-2:VEL_SHIFT];
    vs        = vprod_r[VPROD_W-1] ? -$signed({1'b0, vq}) : $signed({1'b0, vq});
    if (vs > VEL_MAX) begin
      vel_sat = VEL_MAX[VEL_W-1:0];
    end else if (vs < VEL_MIN) begin
      vel_sat = VEL_MIN[VEL_W-1:0];
    end else begin
      vel_sat = vs[VEL_W-1:0];
    end
    vel_ext     = {vel_sat[VEL_W-1], vel_sat};
    vel_db_s    = $signed({2'b00, vel_db});
    vel_in_band = (vel_ext < vel_db_s) && (vel_ext > -vel_db_s);
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc_r <= acc_in_band ? '0 : acc_sat;
    end
    if (ctrl.vmul_en) begin
      vprod_r <= acc_r * $signed({1'b0, period});
    end
    if (ctrl.vrnd_en) begin
      vel_r <= vel_in_band ? '0 : vel_sat;
    end
  end

  assign acc_out = acc_r;
  assign vel_out = vel_r;

endmodule

// ===== sv/mssc_merge.sv =====
// Merge stage: pressure clamp, direction, speed mode, contact, result register.
// Depends on mssc_pkg.
module mssc_merge (
  input  logic                               clk,
  input  logic                               load,
  input  mssc_pkg::acc_t                     acc [mssc_pkg::NUM_AXES],
  input  mssc_pkg::vel_t                     vel [mssc_pkg::NUM_AXES],
  input  logic signed [mssc_pkg::RND_W-1:0]  pres_rnd,
  input  logic [mssc_pkg::PRES_TH_W-1:0]     min_contact,
  output mssc_pkg::acc_t                     acc_o [mssc_pkg::NUM_AXES],
  output mssc_pkg::vel_t                     vel_o [mssc_pkg::NUM_AXES],
  output logic [mssc_pkg::SAMPLE_WIDTH-1:0]  pres_o,
  output mssc_pkg::dir_t                     dir_o,
  output mssc_pkg::mode_t                    mode_o,
  output logic                               contact_o
);
  import mssc_pkg::*;

  localparam logic signed [RND_W-1:0] PRES_MAX = {2'b00, {SAMPLE_WIDTH{1'b1}}};

  logic [SAMPLE_WIDTH-1:0] pres_clamp;
  dir_t                    dir;
  mode_t                   mode;
  acc_t                    acc_r [NUM_AXES];
  vel_t                    vel_r [NUM_AXES];
  logic [SAMPLE_WIDTH-1:0] pres_r;
  dir_t                    dir_r;
  mode_t                   mode_r;
  logic                    contact_r;

  always_comb begin
    if (pres_rnd < 0) begin
      pres_clamp = '0;
    end else if (pres_rnd > PRES_MAX) begin
      pres_clamp = '1;
    end else begin
      pres_clamp = pres_rnd[SAMPLE_WIDTH-1:0];
    end

    if (vel[0] == '0) begin
      dir = DIR_STOP;
    end else if (!vel[0][VEL_W-1]) begin
      dir = DIR_FWD;
    end else begin
      dir = DIR_BACK;
    end

    // Braking opposes the direction of travel, accelerating follows it.
    if (dir == DIR_STOP) begin
      mode = MODE_STOPPED;
    end else if (acc[0] == '0) begin
      mode = MODE_CONST;
    end else if (dir == DIR_FWD) begin
      mode = acc[0][SAMPLE_WIDTH-1] ? MODE_BRAKE : MODE_ACCEL;
    end else begin
      mode = acc[0][SAMPLE_WIDTH-1] ? MODE_ACCEL : MODE_BRAKE;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r     <= acc;
      vel_r     <= vel;
      pres_r    <= pres_clamp;
      dir_r     <= dir;
      mode_r    <= mode;
      contact_r <= ({{(SAMPLE_WIDTH-PRES_TH_W){1'b0}}, min_contact} <= pres_clamp);
    end
  end

  assign acc_o     = acc_r;
  assign vel_o     = vel_r;
  assign pres_o    = pres_r;
  assign dir_o     = dir_r;
  assign mode_o    = mode_r;
  assign contact_o = contact_r;

endmodule

// ===== sv/motion_sample_smoother_classifier.sv =====
// Top level of the motion sample smoother and classifier.
// Depends on mssc_pkg, mssc_ema_lane, mssc_vel_lane, mssc_merge, assert_macros.svh.

// Each request carries a signed Q8.8 three-axis acceleration sample and an
// unsigned Q12.4 pressure sample; each produces exactly one result. Four
// exponential-average lanes (x, y, z, pressure) run side by side with the
// gain given as unsigned Q0.16 and the state held at 16 extra fraction bits,
// starting from zero after reset. The three acceleration lanes then round,
// saturate and deadband their value, multiply it by the loop period and
// round, saturate and deadband the Q8.16 step velocity. A merge stage
// clamps the pressure, derives direction from the x velocity sign, speed mode
// from the x acceleration relative to that direction, and contact from the
// clamped pressure against the threshold, and holds the result in an output
// register. The accept cycle latches the filter difference, then a shared
// sequencer walks every lane through seven steps: gain multiply, state
// update, round, deadband, period multiply, velocity round and merge. Each
// step is one register stage. A new request is taken as soon as the
// sequencer is back in idle, even while the previous result is still held;
// only a result that cannot move into the output register stalls it.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// with no wait; the user must write them only while no request is in flight,
// which the block itself does not enforce. Unknown indexes and data bits
// above a register's width are dropped. There is no clearing pass.

`include "assert_macros.svh"

module motion_sample_smoother_classifier (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // request channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [mssc_pkg::SAMPLE_WIDTH-1:0] in_accel_x,
  input  logic signed [mssc_pkg::SAMPLE_WIDTH-1:0] in_accel_y,
  input  logic signed [mssc_pkg::SAMPLE_WIDTH-1:0] in_accel_z,
  input  logic [mssc_pkg::SAMPLE_WIDTH-1:0]        in_pressure_sample,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [mssc_pkg::SAMPLE_WIDTH-1:0] out_smooth_accel_x,
  output logic signed [mssc_pkg::SAMPLE_WIDTH-1:0] out_smooth_accel_y,
  output logic signed [mssc_pkg::SAMPLE_WIDTH-1:0] out_smooth_accel_z,
  output logic signed [mssc_pkg::VEL_W-1:0]        out_step_vel_x,
  output logic signed [mssc_pkg::VEL_W-1:0]        out_step_vel_y,
  output logic signed [mssc_pkg::VEL_W-1:0]        out_step_vel_z,
  output logic [mssc_pkg::SAMPLE_WIDTH-1:0]        out_smooth_pressure,
  output logic [1:0]                              out_direction,
  output logic [1:0]                              out_speed_mode,
  output logic                                    out_contact,
  // configuration write port
  input  logic                                    cfg_wr_en,
  input  logic [mssc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [mssc_pkg::CFG_DATA_W-1:0]          cfg_data
);
  import mssc_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0]    accel_gain_r, accel_gain_nxt;
  logic [GAIN_W-1:0]    pressure_gain_r, pressure_gain_nxt;
  logic [PERIOD_W-1:0]  loop_period_r, loop_period_nxt;
  logic [ACC_DB_W-1:0]  accel_db_r, accel_db_nxt;
  logic [VEL_DB_W-1:0]  vel_db_r, vel_db_nxt;
  logic [PRES_TH_W-1:0] min_contact_r, min_contact_nxt;

  // Sequencer and output handshake
  seq_state_t state_r, state_nxt;
  lane_ctrl_t ctrl;
  logic       load;
  logic       out_valid_r, out_valid_nxt;

  // Lane data
  logic signed [SAMPLE_WIDTH:0] accel_in [NUM_AXES];
  logic signed [RND_W-1:0]      accel_rnd [NUM_AXES];
  logic signed [RND_W-1:0]      pres_rnd;
  acc_t                         lane_acc [NUM_AXES];
  vel_t                         lane_vel [NUM_AXES];
  acc_t                         res_acc [NUM_AXES];
  vel_t                         res_vel [NUM_AXES];
  dir_t                         res_dir;
  mode_t                        res_mode;

  // Register decoder: drop unknown indexes and surplus data bits.
  always_comb begin
    accel_gain_nxt    = accel_gain_r;
    pressure_gain_nxt = pressure_gain_r;
    loop_period_nxt   = loop_period_r;
    accel_db_nxt      = accel_db_r;
    vel_db_nxt        = vel_db_r;
    min_contact_nxt   = min_contact_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ACCEL_GAIN:    accel_gain_nxt    = cfg_data[GAIN_W-1:0];
        REG_PRESSURE_GAIN: pressure_gain_nxt = cfg_data[GAIN_W-1:0];
        REG_LOOP_PERIOD:   loop_period_nxt   = cfg_data[PERIOD_W-1:0];
        REG_ACCEL_DB:      accel_db_nxt      = cfg_data[ACC_DB_W-1:0];
        REG_VEL_DB:        vel_db_nxt        = cfg_data[VEL_DB_W-1:0];
        REG_MIN_CONTACT:   min_contact_nxt   = cfg_data[PRES_TH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_gain_r    <= ACCEL_GAIN_RST;
      pressure_gain_r <= PRESSURE_GAIN_RST;
      loop_period_r   <= LOOP_PERIOD_RST;
      accel_db_r      <= ACCEL_DB_RST;
      vel_db_r        <= VEL_DB_RST;
      min_contact_r   <= MIN_CONTACT_RST;
    end else begin
      accel_gain_r    <= accel_gain_nxt;
      pressure_gain_r <= pressure_gain_nxt;
      loop_period_r   <= loop_period_nxt;
      accel_db_r      <= accel_db_nxt;
      vel_db_r        <= vel_db_nxt;
      min_contact_r   <= min_contact_nxt;
    end
  end

  // Sequencer: the accept cycle latches the filter difference, then each
  // lane state strobes one step in all lanes at once; merge loads the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.diff_en = 1'b1;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        ctrl.upd_en = 1'b1;
        state_nxt   = ST_RND;
      end
      ST_RND: begin
        ctrl.rnd_en = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        ctrl.acc_en = 1'b1;
        state_nxt   = ST_VMUL;
      end
      ST_VMUL: begin
        ctrl.vmul_en = 1'b1;
        state_nxt    = ST_VRND;
      end
      ST_VRND: begin
        ctrl.vrnd_en = 1'b1;
        state_nxt    = ST_MERGE;
      end
      ST_MERGE: begin
        // Hold here until the output register is free or being drained.
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid_nxt = load | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

  assign accel_in[0] = {in_accel_x[SAMPLE_WIDTH-1], in_accel_x};
  assign accel_in[1] = {in_accel_y[SAMPLE_WIDTH-1], in_accel_y};
  assign accel_in[2] = {in_accel_z[SAMPLE_WIDTH-1], in_accel_z};

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    mssc_ema_lane u_ema (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .sample  (accel_in[g]),
      .gain    (accel_gain_r),
      .rnd_val (accel_rnd[g])
    );

    mssc_vel_lane u_vel (
      .clk     (clk),
      .ctrl    (ctrl),
      .rnd_val (accel_rnd[g]),
      .acc_db  (accel_db_r),
      .period  (loop_period_r),
      .vel_db  (vel_db_r),
      .acc_out (lane_acc[g]),
      .vel_out (lane_vel[g])
    );
  end

  // Pressure is unsigned: zero-extend into its own lane.
  mssc_ema_lane u_pres_ema (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .sample  ($signed({1'b0, in_pressure_sample})),
    .gain    (pressure_gain_r),
    .rnd_val (pres_rnd)
  );

  mssc_merge u_merge (
    .clk         (clk),
    .load        (load),
    .acc         (lane_acc),
    .vel         (lane_vel),
    .pres_rnd    (pres_rnd),
    .min_contact (min_contact_r),
    .acc_o       (res_acc),
    .vel_o       (res_vel),
    .pres_o      (out_smooth_pressure),
    .dir_o       (res_dir),
    .mode_o      (res_mode),
    .contact_o   (out_contact)
  );

  assign out_smooth_accel_x = res_acc[0];
  assign out_smooth_accel_y = res_acc[1];
  assign out_smooth_accel_z = res_acc[2];
  assign out_step_vel_x     = res_vel[0];
  assign out_step_vel_y     = res_vel[1];
  assign out_step_vel_z     = res_vel[2];
  assign out_direction      = res_dir;
  assign out_speed_mode     = res_mode;

  // An accepted request reaches the merge step with no stall on the way.
  `MSSC_ASSERT(a_seq_latency, in_valid && in_ready |-> ##7 state_r == ST_MERGE, "latency broken")
  // A result only appears out of the merge step.
  `MSSC_ASSERT(a_valid_from_merge, $rose(out_valid) |-> $past(state_r == ST_MERGE), "result without merge")
  // Reset empties the output register.
  `MSSC_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result held across reset")

endmodule
